[rtl/core/two_axis_minmax_calibrate_scale_defines.svh]
`ifndef TWO_AXIS_MINMAX_CALIBRATE_SCALE_DEFINES_SVH
`define TWO_AXIS_MINMAX_CALIBRATE_SCALE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TAMCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tamcs: implication failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TAMCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tamcs: next-cycle implication failed");

`endif

[rtl/core/tamcs_pkg.sv]
`default_nettype none

package tamcs_pkg;

  localparam int POS_W      = 24;
  localparam int FRAC_W     = 24;
  localparam int VAL_W      = 15;
  localparam int TICKS_W    = 16;
  localparam int SCALE_W    = VAL_W + FRAC_W;
  localparam int RANGE_W    = POS_W;
  localparam int CNT_W      = $clog2(SCALE_W + 1);
  localparam int SCALE_LO_W = SCALE_W / 2 + 1;
  localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
  localparam int PROD_W     = POS_W + SCALE_W;

  localparam logic [VAL_W-1:0]   FULL_SCALE  = '1;
  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(500);

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic accept;
    logic track;
    logic finish;
    logic clear;
    logic adv;
  } lane_ctl_t;

  typedef struct packed {
    logic                          upd;
    logic [POS_W+SCALE_LO_W-1:0]   lo;
    logic [POS_W+SCALE_HI_W-1:0]   hi;
  } lane_pp_t;

endpackage

`default_nettype wire

[rtl/core/tamcs_in_if.sv]
`default_nettype none

interface tamcs_in_if import tamcs_pkg::*;;
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

[rtl/core/tamcs_out_if.sv]
`default_nettype none

interface tamcs_out_if import tamcs_pkg::*;;
  logic             valid;
  logic             ready;
  logic             x_update;
  logic [VAL_W-1:0] x_value;
  logic             y_update;
  logic [VAL_W-1:0] y_value;
  logic             calibrating_now;

  modport source (output valid, output x_update, output x_value, output y_update,
                  output y_value, output calibrating_now, input ready);
  modport sink   (input valid, input x_update, input x_value, input y_update,
                  input y_value, input calibrating_now, output ready);
endinterface

`default_nettype wire

[rtl/core/two_axis_minmax_calibrate_scale.sv]
// Datapath: front stage, partial-product registers, output registers on out_o.
// Throughput: one word a cycle while out_o is ready and no divider is
// busy; the word that ends calibration holds the front stage while both
// lane dividers run, one quotient bit a cycle.
// Reset: asynchronous, active low; countdown 500, min, max and scale 0,
// output values 0. No clearing pass.
`default_nettype none
`include "two_axis_minmax_calibrate_scale_defines.svh"

module two_axis_minmax_calibrate_scale import tamcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TICKS_W-1:0] cfg_wdata_i,
  tamcs_in_if.sink                in_i,
  tamcs_out_if.source             out_o
);

  logic [TICKS_W-1:0] cnt_q;
  logic               done_q;
  logic               a_v_q, b_v_q, out_v_q;
  logic               a_track_q, b_track_q;
  logic               xu_q, yu_q, cal_q;
  logic [VAL_W-1:0]   xv_q, yv_q;
  logic               accept, track, finish, busy, stall, a_adv, b_adv;
  logic               busy_x, busy_y;
  lane_ctl_t          ctl;
  lane_pp_t           pp_x, pp_y;
  logic [VAL_W-1:0]   val_x, val_y;

  function automatic logic [VAL_W-1:0] scale_out(lane_pp_t pp);
    logic [PROD_W-1:0] prod;
    prod = {pp.hi, SCALE_LO_W'(0)} + PROD_W'(pp.lo);
    return (|prod[PROD_W-1:FRAC_W+VAL_W]) ? FULL_SCALE : prod[FRAC_W+VAL_W-1:FRAC_W];
  endfunction

  always_comb begin
    track  = !done_q && cnt_q != '0;
    finish = !done_q && cnt_q == '0;
    busy   = busy_x || busy_y;
    stall  = out_v_q && !out_o.ready;
    b_adv  = b_v_q && !stall;
    a_adv  = a_v_q && !busy && (!b_v_q || b_adv);
    accept = in_i.valid && in_i.ready;
    ctl    = '{accept: accept, track: track, finish: finish,
               clear: cfg_we_i, adv: a_adv};
    val_x  = scale_out(pp_x);
    val_y  = ~scale_out(pp_y);
  end

  assign in_i.ready = !a_v_q || a_adv;

  tamcs_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pos_i  (in_i.pos_x),
    .busy_o (busy_x),
    .pp_o   (pp_x)
  );

  tamcs_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pos_i  (in_i.pos_y),
    .busy_o (busy_y),
    .pp_o   (pp_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= TICKS_RESET;
      done_q  <= 1'b0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      xu_q    <= 1'b0;
      yu_q    <= 1'b0;
      cal_q   <= 1'b0;
      xv_q    <= '0;
      yv_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cnt_q  <= cfg_wdata_i;
        done_q <= 1'b0;
      end else if (accept) begin
        if (track)  cnt_q  <= cnt_q - TICKS_W'(1);
        if (finish) done_q <= 1'b1;
      end
      if (accept)     a_v_q <= 1'b1;
      else if (a_adv) a_v_q <= 1'b0;
      if (a_adv)      b_v_q <= 1'b1;
      else if (b_adv) b_v_q <= 1'b0;
      if (!stall)     out_v_q <= b_v_q;
      // merge lanes; hold last value where an axis moved by at most one count
      if (b_adv) begin
        xu_q  <= pp_x.upd;
        yu_q  <= pp_y.upd;
        cal_q <= b_track_q;
        if (pp_x.upd) xv_q <= val_x;
        if (pp_y.upd) yv_q <= val_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) a_track_q <= track;
    if (a_adv)  b_track_q <= a_track_q;
  end

  assign out_o.valid           = out_v_q;
  assign out_o.x_update        = xu_q;
  assign out_o.x_value         = xv_q;
  assign out_o.y_update        = yu_q;
  assign out_o.y_value         = yv_q;
  assign out_o.calibrating_now = cal_q;

  `TAMCS_ASSERT_IMP(a_busy_blocks_input, busy, !in_i.ready)
  `TAMCS_ASSERT_NXT(a_finish_starts_div, accept && finish && !cfg_we_i, busy_x && busy_y)
  `TAMCS_ASSERT_IMP(a_cal_x_zero, out_v_q && cal_q && xu_q, xv_q == '0)
  `TAMCS_ASSERT_IMP(a_cal_y_full, out_v_q && cal_q && yu_q, yv_q == FULL_SCALE)

endmodule

`default_nettype wire

[rtl/core/tamcs_div.sv]
`default_nettype none

module tamcs_div import tamcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               clear_i,
  input  wire logic [RANGE_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic [SCALE_W-1:0]      quot_o
);

  logic [RANGE_W-1:0] rem_q, rem_d;
  logic [RANGE_W-1:0] dsr_q;
  logic [SCALE_W-1:0] dvd_q;
  logic [SCALE_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [RANGE_W:0]   sh;
  logic               ge;

  // restoring division, one quotient bit a cycle, dividend MSB first
  always_comb begin
    sh     = {rem_q, dvd_q[SCALE_W-1]};
    ge     = sh >= {1'b0, dsr_q};
    rem_d  = ge ? RANGE_W'(sh - {1'b0, dsr_q}) : sh[RANGE_W-1:0];
    quot_d = {quot_q[SCALE_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      quot_q <= '0;
    end else if (clear_i) begin
      cnt_q  <= '0;
      quot_q <= '0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(SCALE_W);
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dvd_q <= {FULL_SCALE, FRAC_W'(0)};
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[SCALE_W-2:0], 1'b0};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/core/tamcs_lane.sv]
`default_nettype none

module tamcs_lane import tamcs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lane_ctl_t ctl_i,
  input  wire pos_t      pos_i,
  output logic           busy_o,
  output lane_pp_t       pp_o
);

  pos_t               min_q, max_q, last_q;
  logic               a_upd_q;
  logic [POS_W-1:0]   a_mag_q;
  lane_pp_t           pp_q;
  logic [SCALE_W-1:0] scale;
  logic [POS_W:0]     delta, diff, rdiff;
  logic               upd, nz;
  logic [POS_W-1:0]   mag;
  logic [RANGE_W-1:0] range;

  always_comb begin
    nz    = pos_i != '0;
    delta = {pos_i[POS_W-1], pos_i} - {last_q[POS_W-1], last_q};
    upd   = !(delta == '0 || delta == (POS_W+1)'(1) || delta == '1);
    diff  = {pos_i[POS_W-1], pos_i} - {min_q[POS_W-1], min_q};
    // non-positive offsets from min clamp to zero
    mag   = (!diff[POS_W] && diff != '0) ? diff[POS_W-1:0] : '0;
    rdiff = {max_q[POS_W-1], max_q} - {min_q[POS_W-1], min_q};
    range = (max_q == min_q) ? RANGE_W'(1) : rdiff[RANGE_W-1:0];
  end

  tamcs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.accept && ctl_i.finish),
    .clear_i   (ctl_i.clear),
    .divisor_i (range),
    .busy_o    (busy_o),
    .quot_o    (scale)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      last_q <= '0;
    end else begin
      if (ctl_i.clear) begin
        min_q <= '0;
        max_q <= '0;
      end else if (ctl_i.accept && ctl_i.track && nz) begin
        if (pos_i < min_q) min_q <= pos_i;
        if (pos_i > max_q) max_q <= pos_i;
      end
      if (ctl_i.accept && upd) begin
        last_q <= pos_i;
      end
    end
  end

  // split the scale so each partial product stays narrow
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      a_upd_q <= upd;
      a_mag_q <= mag;
    end
    if (ctl_i.adv) begin
      pp_q.upd <= a_upd_q;
      pp_q.lo  <= a_mag_q * scale[SCALE_LO_W-1:0];
      pp_q.hi  <= a_mag_q * scale[SCALE_W-1:SCALE_LO_W];
    end
  end

  assign pp_o = pp_q;

endmodule

`default_nettype wire
